// ===== rtl/rbjd_pkg.sv =====
package rbjd_pkg;

  // One job as held in the running register and in both queues.
  typedef struct packed {
    logic [15:0] io;
    logic [15:0] cpu;
    logic [15:0] start;
    logic [15:0] proc;
  } job_t;

  typedef enum logic [3:0] {
    STS_NO_JOBS       = 4'd0,
    STS_BLOCKED_ONLY  = 4'd1,
    STS_SWITCHED      = 4'd2,
    STS_BLK_TO_READY  = 4'd3,
    STS_BLK_EMPTY     = 4'd4,
    STS_UNIMPL        = 4'd5,
    STS_TO_BLOCKED    = 4'd6,
    STS_FINISHED      = 4'd7,
    STS_DECREMENTED   = 4'd8,
    STS_READY_TO_RUN  = 4'd9,
    STS_ADDED         = 4'd10,
    STS_FULL          = 4'd11
  } status_e;

  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_IRQ  = 2'd2;

  localparam logic [1:0] IRQ_IO_DONE = 2'd0;
  localparam logic [1:0] IRQ_SWITCH  = 2'd1;

  localparam logic [15:0] IO_BLOCKS = 16'd1;
  localparam logic [15:0] CPU_LAST  = 16'd1;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

// ===== rtl/ready_blocked_job_dispatcher_core.sv =====
// Sequence: an accepted event beat passes through S_EXEC to S_DONE, where the result beat
//   is registered; a job loaded from the ready queue adds S_LOAD (one memory read),
//   and an IO-complete interrupt adds an S_MOVE/S_MOVE_WR pass for each job it moves.
// Throughput: one event at a time; the moving loop reads the blocked memory in S_MOVE
//   and writes the ready memory in S_MOVE_WR, in turn for each job.
// Reset: rst_ni clears queue pointers, counts and the running job; memories are not cleared.
module ready_blocked_job_dispatcher_core import rbjd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W = ((65 + 2 * CNT_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,  // proc, start, cpu, io
  input  logic [3:0]       s_axis_tuser,  // func, interrupt_code
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // running_valid, running_process, running_start, running_cpu, running_io,
  // ready_count, blocked_count
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic [3:0]       m_axis_tuser   // status
);

  fifo_ctl_t        rdy_ctl, blk_ctl;
  fifo_sts_t        rdy_sts, blk_sts;
  job_t             rdy_wdata, rdy_rdata, blk_wdata, blk_rdata;
  logic [CNT_W-1:0] rdy_fill, blk_fill;
  status_e          res_status;
  logic             res_run_valid;
  job_t             res_job;
  logic [CNT_W-1:0] res_rdy_cnt, res_blk_cnt;

  rbjd_fifo #(.DEPTH(QUEUE_DEPTH)) u_ready_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rdy_ctl),
    .wdata_i (rdy_wdata),
    .rdata_o (rdy_rdata),
    .sts_o   (rdy_sts),
    .fill_o  (rdy_fill)
  );

  rbjd_fifo #(.DEPTH(QUEUE_DEPTH)) u_blocked_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (blk_ctl),
    .wdata_i (blk_wdata),
    .rdata_o (blk_rdata),
    .sts_o   (blk_sts),
    .fill_o  (blk_fill)
  );

  rbjd_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_valid_i      (s_axis_tvalid),
    .ev_ready_o      (s_axis_tready),
    .ev_func_i       (s_axis_tuser[1:0]),
    .ev_code_i       (s_axis_tuser[3:2]),
    .ev_job_i        (job_t'(s_axis_tdata)),
    .rdy_ctl_o       (rdy_ctl),
    .rdy_wdata_o     (rdy_wdata),
    .rdy_rdata_i     (rdy_rdata),
    .rdy_sts_i       (rdy_sts),
    .rdy_fill_i      (rdy_fill),
    .blk_ctl_o       (blk_ctl),
    .blk_wdata_o     (blk_wdata),
    .blk_rdata_i     (blk_rdata),
    .blk_sts_i       (blk_sts),
    .blk_fill_i      (blk_fill),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_status_o    (res_status),
    .res_run_valid_o (res_run_valid),
    .res_job_o       (res_job),
    .res_rdy_cnt_o   (res_rdy_cnt),
    .res_blk_cnt_o   (res_blk_cnt)
  );

  assign m_axis_tuser = res_status;
  assign m_axis_tdata = OUT_W'({res_blk_cnt, res_rdy_cnt, res_job, res_run_valid});

endmodule

// ===== rtl/rbjd_fifo.sv =====
module rbjd_fifo import rbjd_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fifo_ctl_t        ctl_i,
  input  job_t             wdata_i,
  output job_t             rdata_o,
  output fifo_sts_t        sts_o,
  output logic [CNT_W-1:0] fill_o
);

  job_t             mem_q [DEPTH];
  job_t             rdata_q;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             push_ok, pop_ok;

  assign push_ok = ctl_i.push && (fill_q != CNT_W'(DEPTH));
  assign pop_ok  = ctl_i.pop && (fill_q != '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (pop_ok) begin
      head_d = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    if (push_ok) begin
      tail_d = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // single write port, registered read of the head entry
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (pop_ok) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign rdata_o     = rdata_q;
  assign fill_o      = fill_q;
  assign sts_o.empty = (fill_q == '0);
  assign sts_o.full  = (fill_q == CNT_W'(DEPTH));

endmodule

// ===== rtl/rbjd_ctrl.sv =====
module rbjd_ctrl import rbjd_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // event side
  input  logic             ev_valid_i,
  output logic             ev_ready_o,
  input  logic [1:0]       ev_func_i,
  input  logic [1:0]       ev_code_i,
  input  job_t             ev_job_i,
  // ready queue
  output fifo_ctl_t        rdy_ctl_o,
  output job_t             rdy_wdata_o,
  input  job_t             rdy_rdata_i,
  input  fifo_sts_t        rdy_sts_i,
  input  logic [CNT_W-1:0] rdy_fill_i,
  // blocked queue
  output fifo_ctl_t        blk_ctl_o,
  output job_t             blk_wdata_o,
  input  job_t             blk_rdata_i,
  input  fifo_sts_t        blk_sts_i,
  input  logic [CNT_W-1:0] blk_fill_i,
  // result side
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output status_e          res_status_o,
  output logic             res_run_valid_o,
  output job_t             res_job_o,
  output logic [CNT_W-1:0] res_rdy_cnt_o,
  output logic [CNT_W-1:0] res_blk_cnt_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_LOAD    = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_MOVE_WR = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [1:0]       func_q, code_q;
  job_t             ev_job_q;
  status_e          sts_q, sts_d;
  logic             switch_q, switch_d;
  logic             run_valid_q, run_valid_d;
  job_t             run_job_q, run_job_d;
  job_t             done_job;
  logic             accept, out_load;
  logic             res_valid_q;
  status_e          res_status_q;
  logic             res_run_valid_q;
  job_t             res_job_q;
  logic [CNT_W-1:0] res_rdy_cnt_q, res_blk_cnt_q;

  assign ev_ready_o = (state_q == S_IDLE);
  assign accept     = ev_valid_i && ev_ready_o;
  assign out_load   = (state_q == S_DONE) && (!res_valid_q || res_ready_i);

  always_comb begin
    state_d     = state_q;
    sts_d       = sts_q;
    switch_d    = switch_q;
    run_valid_d = run_valid_q;
    run_job_d   = run_job_q;
    rdy_ctl_o   = '0;
    blk_ctl_o   = '0;
    rdy_wdata_o = run_job_q;
    done_job    = run_job_q;
    done_job.cpu = '0;
    blk_wdata_o = done_job;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (func_q)
          FUNC_ADD: begin
            if (rdy_sts_i.full) begin
              sts_d = STS_FULL;
            end else begin
              rdy_ctl_o.push = 1'b1;
              rdy_wdata_o    = ev_job_q;
              sts_d          = STS_ADDED;
            end
          end
          FUNC_TICK: begin
            if (!run_valid_q) begin
              if (rdy_sts_i.empty) begin
                sts_d = blk_sts_i.empty ? STS_NO_JOBS : STS_BLOCKED_ONLY;
              end else begin
                rdy_ctl_o.pop = 1'b1;
                switch_d      = 1'b0;
                state_d       = S_LOAD;
                sts_d         = STS_READY_TO_RUN;
              end
            end else if (run_job_q.cpu > CPU_LAST) begin
              run_job_d.cpu = run_job_q.cpu - 16'd1;
              sts_d         = STS_DECREMENTED;
            end else begin
              // zero CPU time also ends here, no wrap
              if (run_job_q.io == IO_BLOCKS) begin
                if (blk_sts_i.full) begin
                  sts_d = STS_FULL;
                end else begin
                  blk_ctl_o.push = 1'b1;
                  sts_d          = STS_TO_BLOCKED;
                end
              end else begin
                sts_d = STS_FINISHED;
              end
              run_valid_d = 1'b0;
              run_job_d   = '0;
            end
          end
          FUNC_IRQ: begin
            unique case (code_q)
              IRQ_SWITCH: begin
                if (rdy_sts_i.empty) begin
                  sts_d = blk_sts_i.empty ? STS_NO_JOBS : STS_BLOCKED_ONLY;
                end else begin
                  rdy_ctl_o.pop = 1'b1;
                  switch_d      = run_valid_q;
                  state_d       = S_LOAD;
                  sts_d         = run_valid_q ? STS_SWITCHED : STS_READY_TO_RUN;
                end
              end
              IRQ_IO_DONE: begin
                if (blk_sts_i.empty) begin
                  sts_d = STS_BLK_EMPTY;
                end else if (rdy_sts_i.full) begin
                  sts_d = STS_FULL;
                end else begin
                  state_d = S_MOVE;
                  sts_d   = STS_BLK_TO_READY;
                end
              end
              default: begin
                sts_d = STS_UNIMPL;
              end
            endcase
          end
          default: begin
            sts_d = STS_UNIMPL;
          end
        endcase
      end
      S_LOAD: begin
        // head read lands now; old running job goes to the ready tail
        run_job_d   = rdy_rdata_i;
        run_valid_d = 1'b1;
        if (switch_q) begin
          rdy_ctl_o.push = 1'b1;
          rdy_wdata_o    = run_job_q;
        end
        state_d = S_DONE;
      end
      S_MOVE: begin
        if (!blk_sts_i.empty && !rdy_sts_i.full) begin
          blk_ctl_o.pop = 1'b1;
          state_d       = S_MOVE_WR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MOVE_WR: begin
        rdy_ctl_o.push = 1'b1;
        rdy_wdata_o    = blk_rdata_i;
        state_d        = S_MOVE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sts_q       <= STS_NO_JOBS;
      switch_q    <= 1'b0;
      run_valid_q <= 1'b0;
      run_job_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sts_q       <= sts_d;
      switch_q    <= switch_d;
      run_valid_q <= run_valid_d;
      run_job_q   <= run_job_d;
      res_valid_q <= out_load || (res_valid_q && !res_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= ev_func_i;
      code_q   <= ev_code_i;
      ev_job_q <= ev_job_i;
    end
    if (out_load) begin
      res_status_q    <= sts_q;
      res_run_valid_q <= run_valid_q;
      res_job_q       <= run_job_q;
      res_rdy_cnt_q   <= rdy_fill_i;
      res_blk_cnt_q   <= blk_fill_i;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign res_status_o    = res_status_q;
  assign res_run_valid_o = res_run_valid_q;
  assign res_job_o       = res_job_q;
  assign res_rdy_cnt_o   = res_rdy_cnt_q;
  assign res_blk_cnt_o   = res_blk_cnt_q;

endmodule

// ===== rtl/rbjd_checker.sv =====
module rbjd_checker import rbjd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned OUT_W = ((65 + 2 * CNT_W + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [63:0]      s_axis_tdata,
  input logic [3:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic [3:0]       m_axis_tuser
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // one event in flight: no second beat right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("event accepted while previous one in progress");

  // no running job means all running fields read zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[64:1] == 64'd0)
    else $error("running fields nonzero with no running job");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[64+CNT_W:65] <= CNT_W'(QUEUE_DEPTH)
      && m_axis_tdata[64+2*CNT_W:65+CNT_W] <= CNT_W'(QUEUE_DEPTH)
      && m_axis_tuser <= STS_FULL)
    else $error("count or status out of range");

  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind ready_blocked_job_dispatcher_core rbjd_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rbjd_checker (.*);

// ===== bench/ready_blocked_job_dispatcher_core_tb.sv =====
`timescale 1ns / 1ps

module ready_blocked_job_dispatcher_core_tb;
  import rbjd_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned OUT_W = ((65 + 2 * CNT_W + 7) / 8) * 8;
  localparam int RAND_ITEMS = 1700;
  localparam int CALM_ITEMS = 200;    // tail of the run with no gaps or stalls
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 60;   // margin for an IO-complete that moves a full queue

  localparam logic [1:0] FUNC_RSVD = 2'd3;
  localparam logic [1:0] IRQ_RSVD2 = 2'd2;
  localparam logic [1:0] IRQ_RSVD3 = 2'd3;

  typedef enum logic [1:0] {MIX_PHASE, FILL_PHASE, BLOCK_PHASE} stim_phase_e;

  typedef struct packed {
    status_e    status;
    logic       run_v;
    job_t       run;
    logic [4:0] ready_n;
    logic [4:0] blocked_n;
  } disp_res_t;

  typedef struct packed {
    logic [1:0]  fn;
    logic [1:0]  code;
    logic [63:0] job;    // io, cpu, start, proc from the top
    logic        chk;    // status typed in below
    status_e     sts;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_NO_JOBS},
    '{FUNC_IRQ,  IRQ_SWITCH,  64'h0, 1'b1, STS_NO_JOBS},
    '{FUNC_IRQ,  IRQ_IO_DONE, 64'h0, 1'b1, STS_BLK_EMPTY},
    '{FUNC_IRQ,  IRQ_RSVD2,   64'h0, 1'b1, STS_UNIMPL},
    '{FUNC_IRQ,  IRQ_RSVD3,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STS_UNIMPL},
    '{FUNC_RSVD, IRQ_RSVD3,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STS_UNIMPL},
    // zero cpu with io 1: blocks on the first tick after it is loaded
    '{FUNC_ADD,  IRQ_IO_DONE, 64'h0001_0000_1234_0007, 1'b1, STS_ADDED},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h5555_AAAA_5555_AAAA, 1'b1, STS_READY_TO_RUN},
    '{FUNC_TICK, IRQ_SWITCH,  64'hAAAA_5555_AAAA_5555, 1'b1, STS_TO_BLOCKED},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_BLOCKED_ONLY},
    '{FUNC_IRQ,  IRQ_SWITCH,  64'h0, 1'b1, STS_BLOCKED_ONLY},
    '{FUNC_ADD,  IRQ_RSVD3,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STS_ADDED},
    '{FUNC_ADD,  IRQ_IO_DONE, 64'h0000_0002_0000_0000, 1'b1, STS_ADDED},
    // switch with nothing running loads the head
    '{FUNC_IRQ,  IRQ_SWITCH,  64'h0, 1'b1, STS_READY_TO_RUN},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_DECREMENTED},
    '{FUNC_IRQ,  IRQ_SWITCH,  64'h0, 1'b1, STS_SWITCHED},
    '{FUNC_IRQ,  IRQ_IO_DONE, 64'h0, 1'b1, STS_BLK_TO_READY},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_DECREMENTED},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_FINISHED},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_READY_TO_RUN},
    '{FUNC_IRQ,  IRQ_SWITCH,  64'h0, 1'b1, STS_SWITCHED},
    '{FUNC_TICK, IRQ_IO_DONE, 64'h0, 1'b1, STS_TO_BLOCKED},
    '{FUNC_IRQ,  IRQ_IO_DONE, 64'h0, 1'b0, STS_NO_JOBS},
    '{FUNC_TICK, IRQ_SWITCH,  64'h0, 1'b0, STS_NO_JOBS}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [63:0]      s_axis_tdata;  // proc, start, cpu, io
  logic [3:0]       s_axis_tuser;  // func, interrupt_code
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // running_valid, running_process, running_start, running_cpu, running_io,
  // ready_count, blocked_count
  logic [OUT_W-1:0] m_axis_tdata;
  logic [3:0]       m_axis_tuser;  // status

  ready_blocked_job_dispatcher_core #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  // dispatcher state as the bench sees it
  job_t      ready_jobs[$];
  job_t      held_jobs[$];
  job_t      run_job;
  bit        run_on;
  disp_res_t pending_results[$];
  int        mismatch_cnt;
  int        stall_cycles;
  bit        gaps_on;

  function automatic disp_res_t dispatch_predict(logic [1:0] fn, logic [1:0] code, job_t job);
    disp_res_t res;
    job_t      prev;
    bit        moved;
    status_e   sts;
    sts = STS_UNIMPL;
    if (fn == FUNC_ADD) begin
      if (ready_jobs.size() >= QDEPTH) begin
        sts = STS_FULL;
      end else begin
        ready_jobs.push_back(job);
        sts = STS_ADDED;
      end
    end else if (fn == FUNC_TICK) begin
      if (!run_on) begin
        if (ready_jobs.size() == 0) begin
          sts = (held_jobs.size() == 0) ? STS_NO_JOBS : STS_BLOCKED_ONLY;
        end else begin
          run_job = ready_jobs.pop_front();
          run_on = 1'b1;
          sts = STS_READY_TO_RUN;
        end
      end else if (run_job.cpu > CPU_LAST) begin
        run_job.cpu = run_job.cpu - 16'd1;
        sts = STS_DECREMENTED;
      end else begin
        // zero cpu lands here too: no wrap
        prev = run_job;
        prev.cpu = '0;
        sts = STS_FINISHED;
        if (prev.io == IO_BLOCKS) begin
          if (held_jobs.size() < QDEPTH) begin
            held_jobs.push_back(prev);
            sts = STS_TO_BLOCKED;
          end else begin
            sts = STS_FULL;
          end
        end
        run_job = '0;
        run_on = 1'b0;
      end
    end else if (fn == FUNC_IRQ) begin
      if (code == IRQ_SWITCH) begin
        if (ready_jobs.size() == 0) begin
          sts = (held_jobs.size() == 0) ? STS_NO_JOBS : STS_BLOCKED_ONLY;
        end else if (!run_on) begin
          run_job = ready_jobs.pop_front();
          run_on = 1'b1;
          sts = STS_READY_TO_RUN;
        end else begin
          prev = run_job;
          run_job = ready_jobs.pop_front();
          ready_jobs.push_back(prev);
          sts = STS_SWITCHED;
        end
      end else if (code == IRQ_IO_DONE) begin
        if (held_jobs.size() == 0) begin
          sts = STS_BLK_EMPTY;
        end else begin
          moved = 1'b0;
          while (held_jobs.size() > 0 && ready_jobs.size() < QDEPTH) begin
            ready_jobs.push_back(held_jobs.pop_front());
            moved = 1'b1;
          end
          sts = moved ? STS_BLK_TO_READY : STS_FULL;
        end
      end
    end
    res.status = sts;
    res.run_v = run_on;
    res.run = run_job;
    res.ready_n = 5'(ready_jobs.size());
    res.blocked_n = 5'(held_jobs.size());
    return res;
  endfunction

  function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic send_event(logic [1:0] fn, logic [1:0] code, logic [63:0] data, bit chk,
                            status_e sts);
    disp_res_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= {code, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    want = dispatch_predict(fn, code, job_t'(data));
    if (chk) want.status = sts;
    pending_results.push_back(want);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side: ready runs of random length, with stalls while gaps are on
  initial begin
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (gaps_on) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    disp_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none got status %0d", $time, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(m_axis_tuser));
        check_field("running_valid", 16'(want.run_v), 16'(m_axis_tdata[0]));
        check_field("running_process", want.run.proc, m_axis_tdata[16:1]);
        check_field("running_start", want.run.start, m_axis_tdata[32:17]);
        check_field("running_cpu", want.run.cpu, m_axis_tdata[48:33]);
        check_field("running_io", want.run.io, m_axis_tdata[64:49]);
        check_field("ready_count", 16'(want.ready_n), 16'(m_axis_tdata[65 +: CNT_W]));
        check_field("blocked_count", 16'(want.blocked_n),
                    16'(m_axis_tdata[65 + CNT_W +: CNT_W]));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_phase_e phase;
    logic [1:0]  fn;
    logic [1:0]  code;
    logic [63:0] data;
    job_t        job;
    int          r;
    int          s;
    int          add_pct;
    int          tick_pct;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    mismatch_cnt = 0;
    gaps_on = 1'b1;
    run_on = 1'b0;
    run_job = '0;
    phase = MIX_PHASE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      send_event(DIRECTED[i].fn, DIRECTED[i].code, DIRECTED[i].job, DIRECTED[i].chk,
                 DIRECTED[i].sts);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      // phases: mixed traffic, ready-queue fill, blocked-queue fill (no IO-complete)
      if (n % 64 == 0) phase = stim_phase_e'($urandom_range(0, 2));
      if (n == RAND_ITEMS - CALM_ITEMS) gaps_on = 1'b0;
      case (phase)
        FILL_PHASE: begin
          add_pct = 75;
          tick_pct = 90;
        end
        BLOCK_PHASE: begin
          add_pct = 35;
          tick_pct = 92;
        end
        default: begin
          add_pct = 35;
          tick_pct = 70;
        end
      endcase
      r = $urandom_range(0, 99);
      data = {$urandom, $urandom};
      code = 2'($urandom_range(0, 3));
      if (r < add_pct) fn = FUNC_ADD;
      else if (r < tick_pct) fn = FUNC_TICK;
      else if (r < 98 || phase != MIX_PHASE) fn = FUNC_IRQ;
      else fn = FUNC_RSVD;

      if (fn == FUNC_IRQ) begin
        s = $urandom_range(0, 19);
        if (phase == BLOCK_PHASE || s < 9) code = IRQ_SWITCH;
        else if (s < 17 || phase == FILL_PHASE) code = IRQ_IO_DONE;
        else code = s[0] ? IRQ_RSVD2 : IRQ_RSVD3;
      end else if (fn == FUNC_ADD) begin
        job = job_t'(data);
        // long jobs never leave, so full cpu values go mostly to refused adds
        if (ready_jobs.size() < QDEPTH && $urandom_range(0, 255) != 0)
          job.cpu = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < ((phase == BLOCK_PHASE) ? 80 : 40)) job.io = IO_BLOCKS;
        data = job;
      end
      send_event(fn, code, data, 1'b0, STS_NO_JOBS);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rbjd_pkg.sv
rtl/rbjd_fifo.sv
rtl/rbjd_ctrl.sv
rtl/ready_blocked_job_dispatcher_core.sv
rtl/rbjd_checker.sv
bench/ready_blocked_job_dispatcher_core_tb.sv
